>>> rtl/owbm_pkg.sv
package owbm_pkg;

    localparam int unsigned TIMER_W = 10;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_BYTE = 2'd2;

    localparam logic [1:0] STATUS_PRESENCE = 2'd0;
    localparam logic [1:0] STATUS_NO_DEVICE = 2'd1;
    localparam logic [1:0] STATUS_STUCK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW_TIME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_SAMPLE_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_TAIL_TIME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_CHECK_LIMIT = 3'd6;

    localparam logic [9:0] RESET_LOW_TIME_INIT = 10'd480;
    localparam logic [9:0] PRESENCE_DELAY_INIT = 10'd66;
    localparam logic [9:0] RESET_TAIL_TIME_INIT = 10'd414;
    localparam logic [5:0] SLOT_LOW_TIME_INIT = 6'd1;
    localparam logic [5:0] SLOT_SAMPLE_DELAY_INIT = 6'd14;
    localparam logic [6:0] SLOT_TAIL_TIME_INIT = 7'd45;
    localparam logic [7:0] IDLE_CHECK_LIMIT_INIT = 8'd128;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RCHK      = 4'd1,
        PH_RLOW      = 4'd2,
        PH_RPRES     = 4'd3,
        PH_RTAIL     = 4'd4,
        PH_SLOW      = 4'd5,
        PH_SSAMP     = 4'd6,
        PH_STAIL_REL = 4'd7,
        PH_STAIL_LOW = 4'd8,
        PH_SGAP      = 4'd9
    } phase_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic       line_level;
    } owbm_in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] received_byte;
        logic [1:0] reset_status;
        logic       command_rejected;
    } owbm_out_t;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_delay;
        logic [9:0] reset_tail_time;
        logic [5:0] slot_low_time;
        logic [5:0] slot_sample_delay;
        logic [6:0] slot_tail_time;
        logic [7:0] idle_check_limit;
    } owbm_cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic [TIMER_W-1:0] timer;
        logic [7:0]         shift_byte;
        logic [3:0]         bit_count;
        logic [1:0]         last_status;
    } owbm_state_t;

endpackage

>>> rtl/one_wire_bus_master.sv
// The block is a 1-Wire bus master. Each transaction on the command channel
// (cmd_valid, cmd_stall, cmd) is either a one-microsecond tick carrying the
// sampled line level, a reset command or a byte transfer command.
// Every accepted transaction produces exactly one transaction on the result
// channel (res_valid, res_stall, res), which carries the drive level for the
// next microsecond, the busy and done flags, the received byte, the last
// reset status and a flag for a command rejected while busy.
// A result appears in the cycle after its command is accepted, and one command
// can be accepted in every cycle while the result is not stalled; the rate is set
// by the single state update between the state registers and the result register.
// When the receiver stalls, the result register holds its transaction and
// cmd_stall is raised, so no further command is taken until it is drained.
// Timing registers are written over the cfg channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data), which is always ready; writes should be made while
// the bus master is idle. Indexes beyond the last register are ignored.
// Reset returns the state to idle, clears the received byte and status,
// empties the result register and restores the default timings.
module one_wire_bus_master (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  owbm_pkg::owbm_in_t                  cmd,
    output logic                                res_valid,
    input  logic                                res_stall,
    output owbm_pkg::owbm_out_t                 res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    owbm_pkg::owbm_state_t state_reg;
    owbm_pkg::owbm_state_t state_next;
    owbm_pkg::owbm_cfg_t   cfg_reg;
    owbm_pkg::owbm_out_t   res_reg;
    owbm_pkg::owbm_out_t   res_next;
    logic                  res_valid_reg;
    logic                  cmd_accept;

    assign cmd_stall = res_valid_reg & res_stall;
    assign cmd_accept = cmd_valid & ~cmd_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    owbm_step u_step (
        .st      (state_reg),
        .item    (cmd),
        .cfg     (cfg_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase <= owbm_pkg::PH_IDLE;
            state_reg.timer <= '0;
            state_reg.shift_byte <= '0;
            state_reg.bit_count <= '0;
            state_reg.last_status <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_accept)
            begin
                state_reg <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time <= owbm_pkg::RESET_LOW_TIME_INIT;
            cfg_reg.presence_delay <= owbm_pkg::PRESENCE_DELAY_INIT;
            cfg_reg.reset_tail_time <= owbm_pkg::RESET_TAIL_TIME_INIT;
            cfg_reg.slot_low_time <= owbm_pkg::SLOT_LOW_TIME_INIT;
            cfg_reg.slot_sample_delay <= owbm_pkg::SLOT_SAMPLE_DELAY_INIT;
            cfg_reg.slot_tail_time <= owbm_pkg::SLOT_TAIL_TIME_INIT;
            cfg_reg.idle_check_limit <= owbm_pkg::IDLE_CHECK_LIMIT_INIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                owbm_pkg::REG_RESET_LOW_TIME:
                    cfg_reg.reset_low_time <= cfg_data;
                owbm_pkg::REG_PRESENCE_DELAY:
                    cfg_reg.presence_delay <= cfg_data;
                owbm_pkg::REG_RESET_TAIL_TIME:
                    cfg_reg.reset_tail_time <= cfg_data;
                owbm_pkg::REG_SLOT_LOW_TIME:
                    cfg_reg.slot_low_time <= cfg_data[5:0];
                owbm_pkg::REG_SLOT_SAMPLE_DELAY:
                    cfg_reg.slot_sample_delay <= cfg_data[5:0];
                owbm_pkg::REG_SLOT_TAIL_TIME:
                    cfg_reg.slot_tail_time <= cfg_data[6:0];
                owbm_pkg::REG_IDLE_CHECK_LIMIT:
                    cfg_reg.idle_check_limit <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_count <= owbm_pkg::BITS_PER_BYTE)
        else $error("bit counter beyond one byte");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> res_valid_reg)
        else $error("accepted transaction produced no result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("completion reported while still busy");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.command_rejected |-> res_reg.busy_res)
        else $error("command rejected while idle");

    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.busy_res |-> !res_reg.drive_low)
        else $error("line driven low while idle");

endmodule

>>> rtl/owbm_step.sv
module owbm_step (
    input  owbm_pkg::owbm_state_t st,
    input  owbm_pkg::owbm_in_t    item,
    input  owbm_pkg::owbm_cfg_t   cfg,
    output owbm_pkg::owbm_state_t st_next,
    output owbm_pkg::owbm_out_t   res
);

    logic                         expired;
    logic [owbm_pkg::TIMER_W-1:0] timer_dec;
    logic [3:0]                   count_inc;
    logic                         done;
    logic                         rejected;
    logic                         drive;

    assign expired = (st.timer <= owbm_pkg::TIMER_W'(1));
    assign timer_dec = expired ? '0 : st.timer - owbm_pkg::TIMER_W'(1);
    assign count_inc = st.bit_count + 4'd1;

    always_comb
    begin
        st_next = st;
        done = 1'b0;
        rejected = 1'b0;
        unique case (item.action)
            owbm_pkg::ACT_TICK:
            begin
                unique case (st.phase)
                    owbm_pkg::PH_IDLE:
                    begin
                    end
                    owbm_pkg::PH_RCHK:
                    begin
                        if (item.line_level)
                        begin
                            st_next.phase = owbm_pkg::PH_RLOW;
                            st_next.timer = cfg.reset_low_time;
                        end
                        else
                        begin
                            st_next.timer = timer_dec;
                            if (expired)
                            begin
                                st_next.last_status = owbm_pkg::STATUS_STUCK;
                                st_next.phase = owbm_pkg::PH_IDLE;
                                done = 1'b1;
                            end
                        end
                    end
                    owbm_pkg::PH_RLOW:
                    begin
                        st_next.timer = timer_dec;
                        if (expired)
                        begin
                            st_next.phase = owbm_pkg::PH_RPRES;
                            st_next.timer = cfg.presence_delay;
                        end
                    end
                    owbm_pkg::PH_RPRES:
                    begin
                        st_next.timer = timer_dec;
                        if (expired)
                        begin
                            st_next.last_status = item.line_level ?
                                owbm_pkg::STATUS_NO_DEVICE : owbm_pkg::STATUS_PRESENCE;
                            st_next.phase = owbm_pkg::PH_RTAIL;
                            st_next.timer = cfg.reset_tail_time;
                        end
                    end
                    owbm_pkg::PH_RTAIL:
                    begin
                        st_next.timer = timer_dec;
                        if (expired)
                        begin
                            st_next.phase = owbm_pkg::PH_IDLE;
                            done = 1'b1;
                        end
                    end
                    owbm_pkg::PH_SLOW:
                    begin
                        st_next.timer = timer_dec;
                        if (expired)
                        begin
                            st_next.phase = owbm_pkg::PH_SSAMP;
                            st_next.timer = {4'd0, cfg.slot_sample_delay};
                        end
                    end
                    owbm_pkg::PH_SSAMP:
                    begin
                        st_next.timer = timer_dec;
                        if (expired)
                        begin
                            st_next.shift_byte = {item.line_level, st.shift_byte[7:1]};
                            st_next.phase = st.shift_byte[0] ?
                                owbm_pkg::PH_STAIL_REL : owbm_pkg::PH_STAIL_LOW;
                            st_next.timer = {3'd0, cfg.slot_tail_time};
                        end
                    end
                    owbm_pkg::PH_STAIL_REL, owbm_pkg::PH_STAIL_LOW:
                    begin
                        st_next.timer = timer_dec;
                        if (expired)
                        begin
                            st_next.bit_count = count_inc;
                            if (count_inc >= owbm_pkg::BITS_PER_BYTE)
                            begin
                                st_next.phase = owbm_pkg::PH_IDLE;
                                done = 1'b1;
                            end
                            else
                            begin
                                st_next.phase = owbm_pkg::PH_SGAP;
                            end
                        end
                    end
                    owbm_pkg::PH_SGAP:
                    begin
                        st_next.phase = owbm_pkg::PH_SLOW;
                        st_next.timer = {4'd0, cfg.slot_low_time};
                    end
                    default:
                    begin
                        st_next.phase = owbm_pkg::PH_IDLE;
                    end
                endcase
            end
            owbm_pkg::ACT_RESET:
            begin
                if (st.phase != owbm_pkg::PH_IDLE)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    st_next.phase = owbm_pkg::PH_RCHK;
                    st_next.timer = {2'd0, cfg.idle_check_limit};
                end
            end
            owbm_pkg::ACT_BYTE:
            begin
                if (st.phase != owbm_pkg::PH_IDLE)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    st_next.shift_byte = item.data_byte;
                    st_next.bit_count = 4'd0;
                    st_next.phase = owbm_pkg::PH_SLOW;
                    st_next.timer = {4'd0, cfg.slot_low_time};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (st_next.phase)
            owbm_pkg::PH_RLOW, owbm_pkg::PH_SLOW, owbm_pkg::PH_STAIL_LOW:
                drive = 1'b1;
            owbm_pkg::PH_SSAMP:
                drive = ~st_next.shift_byte[0];
            default:
                drive = 1'b0;
        endcase
        res.drive_low = drive;
        res.busy_res = (st_next.phase != owbm_pkg::PH_IDLE);
        res.done_res = done;
        res.received_byte = st_next.shift_byte;
        res.reset_status = st_next.last_status;
        res.command_rejected = rejected;
    end

endmodule
